// ===== rtl/obb_pkg.sv =====
// Shared types, constants and mode decode for the orthonormal basis builder.
package obb_pkg;

   localparam int VEC_W = 24;
   localparam int RAW_W = 49;
   localparam int UNIT_W = 16;
   localparam int THR_W = 15;
   localparam int FRAC_SHIFT = 14;
   localparam int DIV_STEPS = 29;
   localparam int ROOT_STEPS = 15;

   localparam logic [THR_W-1:0] THR_RESET = 15'd164;
   localparam logic [2*THR_W-1:0] THR_SQ_RESET = 30'(int'(THR_RESET) * int'(THR_RESET));

   localparam logic [3:0] MODE_U = 4'd0;
   localparam logic [3:0] MODE_V = 4'd1;
   localparam logic [3:0] MODE_W = 4'd2;
   localparam logic [3:0] MODE_UV = 4'd3;
   localparam logic [3:0] MODE_VU = 4'd4;
   localparam logic [3:0] MODE_UW = 4'd5;
   localparam logic [3:0] MODE_WU = 4'd6;
   localparam logic [3:0] MODE_VW = 4'd7;
   localparam logic [3:0] MODE_WV = 4'd8;

   typedef enum logic [1:0] {ROLE_U, ROLE_V, ROLE_W} role_type;

   typedef struct packed {
      logic mode_ok;
      role_type role_a;
      role_type role_b;
      logic single;
      logic swap;
   } mode_info_type;

   typedef struct packed {
      logic [3:0] mode;
      logic signed [VEC_W-1:0] first_x;
      logic signed [VEC_W-1:0] first_y;
      logic signed [VEC_W-1:0] first_z;
      logic signed [VEC_W-1:0] second_x;
      logic signed [VEC_W-1:0] second_y;
      logic signed [VEC_W-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] u_x;
      logic signed [UNIT_W-1:0] u_y;
      logic signed [UNIT_W-1:0] u_z;
      logic signed [UNIT_W-1:0] v_x;
      logic signed [UNIT_W-1:0] v_y;
      logic signed [UNIT_W-1:0] v_z;
      logic signed [UNIT_W-1:0] w_x;
      logic signed [UNIT_W-1:0] w_y;
      logic signed [UNIT_W-1:0] w_z;
      logic degenerate;
   } rsp_type;

   function automatic int unit_latency(input int in_w);
      return $clog2(in_w - 14) + 4 + DIV_STEPS + ROOT_STEPS;
   endfunction

   function automatic mode_info_type decode_mode(input logic [3:0] mode);
      mode_info_type info;
      info = '{mode_ok: 1'b1, role_a: ROLE_U, role_b: ROLE_V, single: 1'b0, swap: 1'b0};
      unique case (mode)
         MODE_U: begin
            info.role_a = ROLE_U; info.role_b = ROLE_V; info.single = 1'b1;
         end
         MODE_V: begin
            info.role_a = ROLE_V; info.role_b = ROLE_U; info.single = 1'b1;
         end
         MODE_W: begin
            info.role_a = ROLE_W; info.role_b = ROLE_U; info.single = 1'b1;
         end
         MODE_UV: begin
            info.role_a = ROLE_U; info.role_b = ROLE_W;
         end
         MODE_VU: begin
            info.role_a = ROLE_V; info.role_b = ROLE_W; info.swap = 1'b1;
         end
         MODE_UW: begin
            info.role_a = ROLE_U; info.role_b = ROLE_V; info.swap = 1'b1;
         end
         MODE_WU: begin
            info.role_a = ROLE_W; info.role_b = ROLE_V;
         end
         MODE_VW: begin
            info.role_a = ROLE_V; info.role_b = ROLE_U;
         end
         MODE_WV: begin
            info.role_a = ROLE_W; info.role_b = ROLE_U; info.swap = 1'b1;
         end
         default: info.mode_ok = 1'b0;
      endcase
      return info;
   endfunction

   function automatic role_type third_role(input role_type ra, input role_type rb);
      if (ra != ROLE_U && rb != ROLE_U) return ROLE_U;
      else if (ra != ROLE_V && rb != ROLE_V) return ROLE_V;
      else return ROLE_W;
   endfunction

endpackage

// ===== rtl/obb_norm_unit.sv =====
// Pipelined vector normalizer: range shift, squares, long division and square root.
module obb_norm_unit import obb_pkg::*; #(
   parameter int IN_W = 24,
   parameter int SIDE_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [2:0][IN_W-1:0] in_vec,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   output logic [2:0][UNIT_W-1:0] out_vec,
   output logic out_ok,
   output logic [SIDE_W-1:0] out_side
);

   localparam int SH_STEPS = $clog2(IN_W - 14);
   localparam int LAT = unit_latency(IN_W);
   localparam int MAG_W = 15;
   localparam int SQ_W = 2 * MAG_W;
   localparam int SUM_W = 32;
   localparam int ROOT_W = ROOT_STEPS;
   localparam int X_W = 2 * ROOT_STEPS;
   localparam int RR_W = 18;

   typedef struct packed {
      logic zero;
      logic [2:0] neg;
      logic [SIDE_W-1:0] side;
   } ctl_type;

   ctl_type ctl_in;
   ctl_type ctl_ff [LAT];
   logic [LAT-1:0] vld_ff;

   logic [2:0][IN_W-1:0] mag_ff [SH_STEPS+1];
   logic [2:0][SQ_W-1:0] sq_ff;
   logic [2:0][SQ_W-1:0] sq2_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [2:0][SUM_W-1:0] dv_rem_ff [DIV_STEPS];
   logic [2:0][DIV_STEPS-1:0] dv_quo_ff [DIV_STEPS];
   logic [SUM_W-1:0] dv_den_ff [DIV_STEPS];
   logic [2:0][X_W-1:0] rt_x_ff [ROOT_STEPS];
   logic [2:0][RR_W-1:0] rt_rem_ff [ROOT_STEPS];
   logic [2:0][ROOT_W-1:0] rt_root_ff [ROOT_STEPS];
   logic [2:0][UNIT_W-1:0] out_vec_ff;

   always_comb begin
      ctl_in.zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
      for (int i = 0; i < 3; i++) ctl_in.neg[i] = in_vec[i][IN_W-1];
      ctl_in.side = in_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff[0] <= ctl_in;
      for (int p = 1; p < LAT; p++) ctl_ff[p] <= ctl_ff[p-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag_ff[0][i] <= in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
   end

   // Binary search on the shift: each step halves the remaining range.
   for (genvar j = 0; j < SH_STEPS; j++) begin : g_shift
      localparam int D = 1 << (SH_STEPS - 1 - j);
      logic [IN_W-1:0] any_w;
      logic big_w;
      assign any_w = mag_ff[j][0] | mag_ff[j][1] | mag_ff[j][2];
      assign big_w = |(any_w >> (14 + D));
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[j+1][i] <= big_w ? (mag_ff[j][i] >> D) : mag_ff[j][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= {{(SQ_W-MAG_W){1'b0}}, mag_ff[SH_STEPS][i][MAG_W-1:0]}
                   * {{(SQ_W-MAG_W){1'b0}}, mag_ff[SH_STEPS][i][MAG_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      sq2_ff <= sq_ff;
   end

   // Restoring division of square * 2^28 by the sum, one quotient bit per stage.
   // The upper dividend bits give a zero quotient, so the remainder starts at square / 2.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [2:0][SUM_W-1:0] rem_prev_w;
      logic [2:0][DIV_STEPS-1:0] quo_prev_w;
      logic [2:0] bit_w;
      logic [SUM_W-1:0] den_w;
      if (k == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rem_prev_w[i] = {{(SUM_W-SQ_W+1){1'b0}}, sq2_ff[i][SQ_W-1:1]};
               bit_w[i] = sq2_ff[i][0];
               quo_prev_w[i] = '0;
            end
            den_w = sum_ff;
         end
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               rem_prev_w[i] = dv_rem_ff[k-1][i];
               bit_w[i] = 1'b0;
               quo_prev_w[i] = dv_quo_ff[k-1][i];
            end
            den_w = dv_den_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if ({rem_prev_w[i], bit_w[i]} >= {1'b0, den_w}) begin
               dv_rem_ff[k][i] <= SUM_W'({rem_prev_w[i], bit_w[i]} - {1'b0, den_w});
               dv_quo_ff[k][i] <= {quo_prev_w[i][DIV_STEPS-2:0], 1'b1};
            end else begin
               dv_rem_ff[k][i] <= SUM_W'({rem_prev_w[i], bit_w[i]});
               dv_quo_ff[k][i] <= {quo_prev_w[i][DIV_STEPS-2:0], 1'b0};
            end
         end
         dv_den_ff[k] <= den_w;
      end
   end

   // Digit-by-digit square root, one root bit per stage.
   for (genvar r = 0; r < ROOT_STEPS; r++) begin : g_root
      logic [2:0][X_W-1:0] x_prev_w;
      logic [2:0][RR_W-1:0] rem_prev_w;
      logic [2:0][ROOT_W-1:0] root_prev_w;
      logic [2:0][RR_W+1:0] trial_w;
      logic [2:0][RR_W+1:0] test_w;
      if (r == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               x_prev_w[i] = {{(X_W-DIV_STEPS){1'b0}}, dv_quo_ff[DIV_STEPS-1][i]};
               rem_prev_w[i] = '0;
               root_prev_w[i] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               x_prev_w[i] = rt_x_ff[r-1][i];
               rem_prev_w[i] = rt_rem_ff[r-1][i];
               root_prev_w[i] = rt_root_ff[r-1][i];
            end
         end
      end
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial_w[i] = {rem_prev_w[i], x_prev_w[i][X_W-1:X_W-2]};
            test_w[i] = {{(RR_W-ROOT_W){1'b0}}, root_prev_w[i], 2'b01};
         end
      end
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            rt_x_ff[r][i] <= {x_prev_w[i][X_W-3:0], 2'b00};
            if (trial_w[i] >= test_w[i]) begin
               rt_rem_ff[r][i] <= RR_W'(trial_w[i] - test_w[i]);
               rt_root_ff[r][i] <= {root_prev_w[i][ROOT_W-2:0], 1'b1};
            end else begin
               rt_rem_ff[r][i] <= RR_W'(trial_w[i]);
               rt_root_ff[r][i] <= {root_prev_w[i][ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (ctl_ff[LAT-2].zero) begin
            out_vec_ff[i] <= '0;
         end else if (ctl_ff[LAT-2].neg[i]) begin
            out_vec_ff[i] <= ~{1'b0, rt_root_ff[ROOT_STEPS-1][i]} + 1'b1;
         end else begin
            out_vec_ff[i] <= {1'b0, rt_root_ff[ROOT_STEPS-1][i]};
         end
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_vec = out_vec_ff;
   assign out_ok = !ctl_ff[LAT-1].zero;
   assign out_side = ctl_ff[LAT-1].side;

endmodule

// ===== rtl/orthonormal_basis_builder.sv =====
// Top level of the orthonormal basis builder: operand setup, perpendicular, final cross.
//
//  channel   ports                            direction  handshake
//  request   start, busy, req_data            in         start && !busy
//  response  rsp_valid, rsp_data              out        one-cycle strobe
//  config    csr_valid, csr_ready, csr_data   in         csr_valid && csr_ready
//
// One item enters every cycle; busy stays low. Each result follows its item through
// two normalizer pipelines (52 and 54 stages, set by the
// 29-stage division and 15-stage square root) and seven stages around them.
// Synchronous reset clears the valid bits and loads the threshold with 164.
// Nothing stalls: the receiver takes each result in its single strobe cycle.
module orthonormal_basis_builder import obb_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [THR_W-1:0] csr_data
);

   localparam int LAT_A = unit_latency(VEC_W);
   localparam int LAT_B = unit_latency(RAW_W);
   localparam int TOT_LAT = 3 + LAT_A + 2 + LAT_B + 2;

   typedef struct packed {
      mode_info_type info;
      logic [2:0][RAW_W-1:0] raw;
   } side_a_type;

   typedef struct packed {
      mode_info_type info;
      logic [2:0][UNIT_W-1:0] g;
      logic ok_a;
   } side_b_type;

   function automatic logic [RAW_W-1:0] ext(input logic [UNIT_W-1:0] x, input logic neg);
      logic signed [RAW_W-1:0] e;
      e = RAW_W'($signed(x));
      return neg ? -e : e;
   endfunction

   function automatic logic [2:0][UNIT_W-1:0] pick(input role_type want, input role_type ra,
         input role_type rb, input logic [2:0][UNIT_W-1:0] ga,
         input logic [2:0][UNIT_W-1:0] gb);
      if (ra == want) return ga;
      else if (rb == want) return gb;
      else return '0;
   endfunction

   function automatic logic [UNIT_W-1:0] round_sat(input logic signed [32:0] t);
      logic signed [32:0] r;
      r = (t + 33'sd8192) >>> FRAC_SHIFT;
      if (r > 33'sd32767) return 16'h7fff;
      else if (r < -33'sd32768) return 16'h8000;
      else return r[UNIT_W-1:0];
   endfunction

   // Configuration
   logic [THR_W-1:0] thr_ff;
   logic [2*THR_W-1:0] thr_sq_ff;
   logic [2*THR_W-1:0] thr_sq_in;

   assign csr_ready = 1'b1;
   assign busy = 1'b0;
   assign thr_sq_in = {{THR_W{1'b0}}, thr_ff} * {{THR_W{1'b0}}, thr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         thr_sq_ff <= THR_SQ_RESET;
      end else begin
         if (csr_valid && csr_ready) thr_ff <= csr_data;
         thr_sq_ff <= thr_sq_in;
      end
   end

   // Input register, raw cross product of the two vectors
   mode_info_type info_in;
   logic v0_ff, v1_ff, v2_ff;
   mode_info_type info0_ff, info1_ff, info2_ff;
   logic [2:0][VEC_W-1:0] f0_ff, f1_ff, f2_ff, ca0_ff, cb0_ff;
   logic signed [2*VEC_W-1:0] pr_ff [6];
   logic [2:0][RAW_W-1:0] raw2_ff;

   assign info_in = decode_mode(req_data.mode);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      info0_ff <= info_in;
      f0_ff <= {req_data.first_z, req_data.first_y, req_data.first_x};
      if (info_in.swap) begin
         ca0_ff <= {req_data.second_z, req_data.second_y, req_data.second_x};
         cb0_ff <= {req_data.first_z, req_data.first_y, req_data.first_x};
      end else begin
         ca0_ff <= {req_data.first_z, req_data.first_y, req_data.first_x};
         cb0_ff <= {req_data.second_z, req_data.second_y, req_data.second_x};
      end
      info1_ff <= info0_ff;
      f1_ff <= f0_ff;
      pr_ff[0] <= $signed(ca0_ff[1]) * $signed(cb0_ff[2]);
      pr_ff[1] <= $signed(ca0_ff[2]) * $signed(cb0_ff[1]);
      pr_ff[2] <= $signed(ca0_ff[2]) * $signed(cb0_ff[0]);
      pr_ff[3] <= $signed(ca0_ff[0]) * $signed(cb0_ff[2]);
      pr_ff[4] <= $signed(ca0_ff[0]) * $signed(cb0_ff[1]);
      pr_ff[5] <= $signed(ca0_ff[1]) * $signed(cb0_ff[0]);
      info2_ff <= info1_ff;
      f2_ff <= f1_ff;
      raw2_ff[0] <= RAW_W'(pr_ff[0]) - RAW_W'(pr_ff[1]);
      raw2_ff[1] <= RAW_W'(pr_ff[2]) - RAW_W'(pr_ff[3]);
      raw2_ff[2] <= RAW_W'(pr_ff[4]) - RAW_W'(pr_ff[5]);
   end

   // First normalizer: main axis from the first vector
   side_a_type side_a_in, side_a_out;
   logic a_valid, a_ok;
   logic [2:0][UNIT_W-1:0] a_vec;

   assign side_a_in = '{info: info2_ff, raw: raw2_ff};

   obb_norm_unit #(.IN_W(VEC_W), .SIDE_W($bits(side_a_type))) u_norm_a (
      .clock(clock), .reset(reset),
      .in_valid(v2_ff), .in_vec(f2_ff), .in_side(side_a_in),
      .out_valid(a_valid), .out_vec(a_vec), .out_ok(a_ok), .out_side(side_a_out)
   );

   // Perpendicular with y-axis fallback, or the raw cross product
   logic p1_valid_ff, p2_valid_ff;
   logic signed [31:0] gy2_w, gz2_w;
   logic [2*THR_W-1:0] gy2_ff, gz2_ff;
   logic [2:0][UNIT_W-1:0] g1_ff;
   logic ok1_ff;
   side_a_type side1_ff;
   logic [2*THR_W:0] len2_w;
   logic short_w;
   logic [2:0][RAW_W-1:0] b_in_ff;
   side_b_type side_b_ff;

   assign gy2_w = $signed(a_vec[1]) * $signed(a_vec[1]);
   assign gz2_w = $signed(a_vec[2]) * $signed(a_vec[2]);
   assign len2_w = {1'b0, gy2_ff} + {1'b0, gz2_ff};
   assign short_w = len2_w < {1'b0, thr_sq_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= a_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      gy2_ff <= gy2_w[2*THR_W-1:0];
      gz2_ff <= gz2_w[2*THR_W-1:0];
      g1_ff <= a_vec;
      ok1_ff <= a_ok;
      side1_ff <= side_a_out;
      if (!side1_ff.info.single) begin
         b_in_ff <= side1_ff.raw;
      end else if (short_w) begin
         b_in_ff[0] <= ext(g1_ff[2], 1'b1);
         b_in_ff[1] <= '0;
         b_in_ff[2] <= ext(g1_ff[0], 1'b0);
      end else begin
         b_in_ff[0] <= '0;
         b_in_ff[1] <= ext(g1_ff[2], 1'b0);
         b_in_ff[2] <= ext(g1_ff[1], 1'b1);
      end
      side_b_ff <= '{info: side1_ff.info, g: g1_ff, ok_a: ok1_ff};
   end

   // Second normalizer: plane axis
   side_b_type side_b_out;
   logic b_valid, b_ok;
   logic [2:0][UNIT_W-1:0] b_vec;

   obb_norm_unit #(.IN_W(RAW_W), .SIDE_W($bits(side_b_type))) u_norm_b (
      .clock(clock), .reset(reset),
      .in_valid(p2_valid_ff), .in_vec(b_in_ff), .in_side(side_b_ff),
      .out_valid(b_valid), .out_vec(b_vec), .out_ok(b_ok), .out_side(side_b_out)
   );

   // Third axis as the cross product of the other two in cyclic order
   role_type rc_w;
   logic [2:0][UNIT_W-1:0] u_w, v_w, w_w, x_w, y_w;
   logic signed [31:0] cp_w [6];
   logic signed [31:0] cp_ff [6];
   logic [2:0][UNIT_W-1:0] u_ff, v_ff, w_ff;
   role_type rc_ff;
   logic c1_valid_ff, c1_ok_ff;
   logic [2:0][UNIT_W-1:0] cr_w;
   rsp_type rsp_in, rsp_ff;
   logic rsp_valid_ff;

   always_comb begin
      rc_w = third_role(side_b_out.info.role_a, side_b_out.info.role_b);
      u_w = pick(ROLE_U, side_b_out.info.role_a, side_b_out.info.role_b, side_b_out.g, b_vec);
      v_w = pick(ROLE_V, side_b_out.info.role_a, side_b_out.info.role_b, side_b_out.g, b_vec);
      w_w = pick(ROLE_W, side_b_out.info.role_a, side_b_out.info.role_b, side_b_out.g, b_vec);
      unique case (rc_w)
         ROLE_U: begin
            x_w = v_w; y_w = w_w;
         end
         ROLE_V: begin
            x_w = w_w; y_w = u_w;
         end
         default: begin
            x_w = u_w; y_w = v_w;
         end
      endcase
      cp_w[0] = $signed(x_w[1]) * $signed(y_w[2]);
      cp_w[1] = $signed(x_w[2]) * $signed(y_w[1]);
      cp_w[2] = $signed(x_w[2]) * $signed(y_w[0]);
      cp_w[3] = $signed(x_w[0]) * $signed(y_w[2]);
      cp_w[4] = $signed(x_w[0]) * $signed(y_w[1]);
      cp_w[5] = $signed(x_w[1]) * $signed(y_w[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= b_valid;
         rsp_valid_ff <= c1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) cp_ff[i] <= cp_w[i];
      u_ff <= u_w;
      v_ff <= v_w;
      w_ff <= w_w;
      rc_ff <= rc_w;
      c1_ok_ff <= side_b_out.info.mode_ok && side_b_out.ok_a && b_ok;
   end

   always_comb begin
      cr_w[0] = round_sat(33'(cp_ff[0]) - 33'(cp_ff[1]));
      cr_w[1] = round_sat(33'(cp_ff[2]) - 33'(cp_ff[3]));
      cr_w[2] = round_sat(33'(cp_ff[4]) - 33'(cp_ff[5]));
      rsp_in = '0;
      rsp_in.degenerate = 1'b1;
      if (c1_ok_ff) begin
         rsp_in.degenerate = 1'b0;
         {rsp_in.u_z, rsp_in.u_y, rsp_in.u_x} = (rc_ff == ROLE_U) ? cr_w : u_ff;
         {rsp_in.v_z, rsp_in.v_y, rsp_in.v_x} = (rc_ff == ROLE_V) ? cr_w : v_ff;
         {rsp_in.w_z, rsp_in.w_y, rsp_in.w_x} = (rc_ff == ROLE_W) ? cr_w : w_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##TOT_LAT rsp_valid)
      else $error("accepted item produced no result strobe");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, TOT_LAT))
      else $error("result strobe does not match an accepted item");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.u_x == '0 && rsp_data.u_y == '0 && rsp_data.u_z == '0 &&
         rsp_data.v_x == '0 && rsp_data.v_y == '0 && rsp_data.v_z == '0 &&
         rsp_data.w_x == '0 && rsp_data.w_y == '0 && rsp_data.w_z == '0)
      else $error("degenerate result carries a nonzero basis");

   a_bad_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.mode > MODE_WV, TOT_LAT) |-> rsp_data.degenerate)
      else $error("unused mode did not flag a degenerate result");

endmodule
